>>> src/periodic_boundary_image_gen_unit_assert.svh
// ----------------------------------------------------------------------------
// Periodic boundary image generator: assertion macros
// Shared property forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_BOUNDARY_IMAGE_GEN_UNIT_ASSERT_SVH
`define PERIODIC_BOUNDARY_IMAGE_GEN_UNIT_ASSERT_SVH

// same-cycle implication
`define PBIG_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbig: implication violated");

// next-cycle implication
`define PBIG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbig: next-cycle implication violated");

`endif

>>> src/pbig_pkg.sv
// ----------------------------------------------------------------------------
// Periodic boundary image generator: package
// Shared widths, configuration layout and saturating fixed-point helpers.
// ----------------------------------------------------------------------------
package pbig_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int COEF_WIDTH  = 21;
  localparam int ROW_W       = 63;
  localparam int CNT_W       = 24;
  localparam int TOL_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int FLIP_W      = 3;
  localparam int NUM_SLOTS   = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int WIDE_W      = 90;
  localparam int INV_SHIFT   = 18;
  localparam int FWD_SHIFT   = 12;

  localparam logic [CNT_W-1:0] CNT_RESET = 24'h010101;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

  // original first, then x-outer / z-inner subsets
  localparam logic [NUM_SLOTS-1:0][FLIP_W-1:0] FLIP_ORDER =
    {3'd7, 3'd3, 3'd5, 3'd1, 3'd6, 3'd2, 3'd4, 3'd0};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FWD_X, CFG_FWD_Y, CFG_FWD_Z,
    CFG_INV_X, CFG_INV_Y, CFG_INV_Z,
    CFG_REP_COUNTS, CFG_EDGE_TOL
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0][ROW_W-1:0] fwd;
    logic [2:0][ROW_W-1:0] inv;
    logic [CNT_W-1:0]      counts;
    logic [TOL_W-1:0]      tol;
  } cfg_t;

  function automatic logic signed [63:0] sat64(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-64:0] hi;
    logic signed [63:0] r;
    hi = v[WIDE_W-1:63];
    if ((&hi) || !(|hi)) r = v[63:0];
    else if (v[WIDE_W-1]) r = {1'b1, {63{1'b0}}};
    else r = {1'b0, {63{1'b1}}};
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [WIDE_W-1:0] s;
    s = {{(WIDE_W-64){a[63]}}, a} + {{(WIDE_W-64){b[63]}}, b};
    return sat64(s);
  endfunction

  function automatic logic signed [63:0] dot3(input logic signed [63:0] p0,
                                              input logic signed [63:0] p1,
                                              input logic signed [63:0] p2);
    return sat_add64(sat_add64(p0, p1), p2);
  endfunction

  function automatic logic signed [63:0] round_sh(input logic signed [63:0] v,
                                                  input int unsigned s);
    logic signed [63:0] r;
    r = sat_add64(v, 64'sd1 <<< (s - 1));
    return r >>> s;
  endfunction

endpackage

>>> src/pbig_in_if.sv
// ----------------------------------------------------------------------------
// Periodic boundary image generator: input channel
// Valid/ready channel carrying one atom position per word.
// ----------------------------------------------------------------------------
interface pbig_in_if #(
  parameter int COORD_WIDTH = pbig_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

>>> src/pbig_out_if.sv
// ----------------------------------------------------------------------------
// Periodic boundary image generator: result channel
// Valid/ready channel carrying one image position per word.
// ----------------------------------------------------------------------------
interface pbig_out_if #(
  parameter int COORD_WIDTH = pbig_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic [2:0]                    flip_mask;
  logic                          last_image;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output flip_mask, output last_image, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input flip_mask, input last_image, output ready);
endinterface

>>> src/pbig_front.sv
// ----------------------------------------------------------------------------
// Periodic boundary image generator: front end
// Maps a position to lattice coordinates and flags boundary axes (2 stages).
// ----------------------------------------------------------------------------
module pbig_front #(
  parameter int COORD_WIDTH = pbig_pkg::COORD_WIDTH,
  parameter int COEF_WIDTH  = pbig_pkg::COEF_WIDTH,
  parameter int NW          = 37
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pbig_pkg::cfg_t                    cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0][COORD_WIDTH-1:0]       in_pos,
  output logic                              f_valid,
  input  logic                              f_ready,
  output logic [2:0][COORD_WIDTH-1:0]       f_pos,
  output logic [2:0][NW-1:0]                f_nrm,
  output logic [2:0]                        f_bmask
);
  localparam int PW = COEF_WIDTH + COORD_WIDTH;
  localparam int WW = pbig_pkg::WIDE_W;

  logic                          s1_v_r;
  logic [2:0][COORD_WIDTH-1:0]   s1_pos_r;
  logic signed [63:0]            s1_prod_r [3][3];
  logic signed [63:0]            prod_nxt  [3][3];
  logic                          s2_v_r;
  logic [2:0][COORD_WIDTH-1:0]   s2_pos_r;
  logic [2:0][NW-1:0]            s2_nrm_r;
  logic [2:0]                    s2_bm_r;
  logic [2:0][NW-1:0]            nrm_nxt;
  logic [2:0]                    bm_nxt;
  logic                          s1_ready, s2_ready;

  assign s2_ready = !s2_v_r || f_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ready = s1_ready;

  always_comb begin
    logic signed [COEF_WIDTH-1:0]  c;
    logic signed [COORD_WIDTH-1:0] p;
    logic signed [PW-1:0]          m;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        c = cfg.inv[i][j*COEF_WIDTH +: COEF_WIDTH];
        p = in_pos[j];
        m = c * p;
        prod_nxt[i][j] = pbig_pkg::sat64({{(WW-PW){m[PW-1]}}, m});
      end
    end
  end

  always_comb begin
    logic signed [63:0] n, d, an, ad, cx, tx;
    for (int i = 0; i < 3; i++) begin
      n  = pbig_pkg::round_sh(pbig_pkg::dot3(s1_prod_r[i][0], s1_prod_r[i][1],
                                             s1_prod_r[i][2]), pbig_pkg::INV_SHIFT);
      cx = {40'b0, cfg.counts[8*i +: 8], 16'b0};
      tx = {48'b0, cfg.tol};
      d  = n - cx;
      an = n[63] ? -n : n;
      ad = d[63] ? -d : d;
      nrm_nxt[i] = n[NW-1:0];
      bm_nxt[i]  = (an < tx) || (ad < tx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ready) s1_v_r <= in_valid;
      if (s2_ready) s2_v_r <= s1_v_r;
    end
    if (s1_ready && in_valid) begin
      s1_pos_r  <= in_pos;
      s1_prod_r <= prod_nxt;
    end
    if (s2_ready && s1_v_r) begin
      s2_pos_r <= s1_pos_r;
      s2_nrm_r <= nrm_nxt;
      s2_bm_r  <= bm_nxt;
    end
  end

  assign f_valid = s2_v_r;
  assign f_pos   = s2_pos_r;
  assign f_nrm   = s2_nrm_r;
  assign f_bmask = s2_bm_r;
endmodule

>>> src/pbig_queue.sv
// ----------------------------------------------------------------------------
// Periodic boundary image generator: classified-atom queue
// Small FIFO decoupling the front end from the image back end.
// ----------------------------------------------------------------------------
module pbig_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pbig_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      cnt_r;
  logic             push, pop;

  assign wr_ready = cnt_r != (AW+1)'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end
endmodule

>>> src/pbig_back.sv
// ----------------------------------------------------------------------------
// Periodic boundary image generator: back end
// Walks the image subsets of the head atom and maps each back to Cartesian.
// ----------------------------------------------------------------------------
module pbig_back #(
  parameter int COORD_WIDTH = pbig_pkg::COORD_WIDTH,
  parameter int COEF_WIDTH  = pbig_pkg::COEF_WIDTH,
  parameter int NW          = 37
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pbig_pkg::cfg_t                cfg,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  logic [2:0][COORD_WIDTH-1:0]   q_pos,
  input  logic [2:0][NW-1:0]            q_nrm,
  input  logic [2:0]                    q_bmask,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0][COORD_WIDTH-1:0]   out_pos,
  output logic [2:0]                    out_flip,
  output logic                          out_last
);
  localparam int MW  = ((NW > 25) ? NW : 25) + 1;
  localparam int FPW = COEF_WIDTH + MW;
  localparam int WW  = pbig_pkg::WIDE_W;

  logic [2:0]                  k_r, next_k;
  logic [7:0]                  vld, higher;
  logic                        is_last, a_ld, a_ready, b_ld;
  logic [2:0]                  flip;
  logic                        a_v_r, a_last_r;
  logic [2:0]                  a_flip_r;
  logic [2:0][COORD_WIDTH-1:0] a_pos_r;
  logic signed [63:0]          a_prod_r [3][3];
  logic signed [63:0]          prod_nxt [3][3];
  logic                        b_v_r, b_last_r;
  logic [2:0]                  b_flip_r;
  logic [2:0][COORD_WIDTH-1:0] b_pos_r, res_nxt;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      vld[k]    = (pbig_pkg::FLIP_ORDER[k] & ~q_bmask) == 3'b0;
      higher[k] = vld[k] && (3'(k) > k_r);
    end
    is_last = higher == 8'b0;
    next_k  = '0;
    for (int k = 7; k >= 0; k--) begin
      if (higher[k]) next_k = 3'(k);
    end
  end

  assign flip    = pbig_pkg::FLIP_ORDER[k_r];
  assign b_ld    = a_v_r && (!b_v_r || out_ready);
  assign a_ready = !a_v_r || b_ld;
  assign a_ld    = q_valid && a_ready;
  assign q_ready = a_ld && is_last;

  always_comb begin
    logic signed [MW-1:0]         mv [3];
    logic signed [MW-1:0]         cx, nx;
    logic signed [COEF_WIDTH-1:0] c;
    logic signed [FPW-1:0]        p;
    for (int j = 0; j < 3; j++) begin
      cx = {{(MW-24){1'b0}}, cfg.counts[8*j +: 8], 16'b0};
      nx = {{(MW-NW){q_nrm[j][NW-1]}}, q_nrm[j]};
      mv[j] = flip[j] ? (cx - nx) : nx;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        c = cfg.fwd[i][j*COEF_WIDTH +: COEF_WIDTH];
        p = c * mv[j];
        prod_nxt[i][j] = pbig_pkg::sat64({{(WW-FPW){p[FPW-1]}}, p});
      end
    end
  end

  always_comb begin
    logic signed [63:0]         r;
    logic [64-COORD_WIDTH:0]    hi;
    for (int i = 0; i < 3; i++) begin
      r  = pbig_pkg::round_sh(pbig_pkg::dot3(a_prod_r[i][0], a_prod_r[i][1],
                                             a_prod_r[i][2]), pbig_pkg::FWD_SHIFT);
      hi = r[63:COORD_WIDTH-1];
      if (a_flip_r == 3'b0) res_nxt[i] = a_pos_r[i];
      else if ((&hi) || !(|hi)) res_nxt[i] = r[COORD_WIDTH-1:0];
      else if (r[63]) res_nxt[i] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      else res_nxt[i] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r   <= '0;
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_ld) k_r <= is_last ? 3'b0 : next_k;
      if (a_ready) a_v_r <= q_valid;
      if (b_ld) b_v_r <= 1'b1;
      else if (out_ready) b_v_r <= 1'b0;
    end
    if (a_ld) begin
      a_pos_r  <= q_pos;
      a_prod_r <= prod_nxt;
      a_flip_r <= flip;
      a_last_r <= is_last;
    end
    if (b_ld) begin
      b_pos_r  <= res_nxt;
      b_flip_r <= a_flip_r;
      b_last_r <= a_last_r;
    end
  end

  assign out_valid = b_v_r;
  assign out_pos   = b_pos_r;
  assign out_flip  = b_flip_r;
  assign out_last  = b_last_r;
endmodule

>>> src/periodic_boundary_image_gen_unit.sv
// ----------------------------------------------------------------------------
// Periodic boundary image generator
// Emits an atom position and its mirrored periodic images near cell faces.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one atom position (pos_x/y/z, Q16.16) per word, valid/ready.
//   out_ch : 1 to 8 words per atom: the original position (flip_mask 0),
//            then one mirrored image per nonempty subset of boundary axes
//            in flip_mask order 4,2,6,1,5,3,7; last_image marks the final one.
//   cfg_*  : register writes (index 0..7), only while the block is idle.
// Path: front stages s1, s2, the queue, then back stages a, b to out_ch.
// Throughput: one result word per cycle while out_ch.ready is high; the back
//   end issues all results of an atom (1 for interior atoms, up to 8) before
//   the next. The single forward-map stage pair in the back end sets this;
//   the front end accepts one atom per cycle while its 4-entry queue has room.
// Reset: pipelines and queue empty, matrices zero, counts 1/1/1,
//   tolerance 66.
// Stall: when out_ch.ready is low the result word holds; the back end,
//   queue and front end fill and then drop in_ch.ready.
// ----------------------------------------------------------------------------
module periodic_boundary_image_gen_unit #(
  parameter int COORD_WIDTH = pbig_pkg::COORD_WIDTH,
  parameter int COEF_WIDTH  = pbig_pkg::COEF_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  pbig_in_if.sink                         in_ch,
  pbig_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [pbig_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [pbig_pkg::ROW_W-1:0]      cfg_data
);
  localparam int PW = COEF_WIDTH + COORD_WIDTH;
  localparam int AW = (PW + 2 > 64) ? 64 : PW + 2;
  localparam int NW = AW - pbig_pkg::INV_SHIFT;
  localparam int EW = 3*COORD_WIDTH + 3*NW + 3;

  pbig_pkg::cfg_t              cfg_r;
  logic [2:0][COORD_WIDTH-1:0] in_pos, f_pos, q_pos, o_pos;
  logic [2:0][NW-1:0]          f_nrm, q_nrm;
  logic [2:0]                  f_bm, q_bm;
  logic                        f_valid, f_ready, q_valid, q_ready;
  logic [EW-1:0]               q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fwd    <= '0;
      cfg_r.inv    <= '0;
      cfg_r.counts <= pbig_pkg::CNT_RESET;
      cfg_r.tol    <= pbig_pkg::TOL_RESET;
    end else if (cfg_we) begin
      unique case (pbig_pkg::cfg_idx_t'(cfg_idx))
        pbig_pkg::CFG_FWD_X:      cfg_r.fwd[0] <= cfg_data;
        pbig_pkg::CFG_FWD_Y:      cfg_r.fwd[1] <= cfg_data;
        pbig_pkg::CFG_FWD_Z:      cfg_r.fwd[2] <= cfg_data;
        pbig_pkg::CFG_INV_X:      cfg_r.inv[0] <= cfg_data;
        pbig_pkg::CFG_INV_Y:      cfg_r.inv[1] <= cfg_data;
        pbig_pkg::CFG_INV_Z:      cfg_r.inv[2] <= cfg_data;
        pbig_pkg::CFG_REP_COUNTS: cfg_r.counts <= cfg_data[pbig_pkg::CNT_W-1:0];
        pbig_pkg::CFG_EDGE_TOL:   cfg_r.tol    <= cfg_data[pbig_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_pos = {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};

  pbig_front #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH), .NW(NW)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_pos(in_pos),
    .f_valid(f_valid), .f_ready(f_ready), .f_pos(f_pos), .f_nrm(f_nrm), .f_bmask(f_bm)
  );

  assign q_wdata = {f_pos, f_nrm, f_bm};

  pbig_queue #(.WIDTH(EW), .DEPTH(pbig_pkg::QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(q_wdata),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_rdata)
  );

  assign q_bm  = q_rdata[2:0];
  assign q_nrm = q_rdata[3 +: 3*NW];
  assign q_pos = q_rdata[3+3*NW +: 3*COORD_WIDTH];

  pbig_back #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH), .NW(NW)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_valid(q_valid), .q_ready(q_ready), .q_pos(q_pos), .q_nrm(q_nrm), .q_bmask(q_bm),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_pos(o_pos),
    .out_flip(out_ch.flip_mask), .out_last(out_ch.last_image)
  );

  assign out_ch.out_x = o_pos[0];
  assign out_ch.out_y = o_pos[1];
  assign out_ch.out_z = o_pos[2];
endmodule

>>> src/pbig_chk.sv
// ----------------------------------------------------------------------------
// Periodic boundary image generator: port checker
// Checks result framing against accepted atoms, bound to the top level.
// ----------------------------------------------------------------------------
`include "periodic_boundary_image_gen_unit_assert.svh"

module pbig_chk #(
  parameter int COORD_WIDTH = pbig_pkg::COORD_WIDTH
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [COORD_WIDTH-1:0] out_x,
  input logic [COORD_WIDTH-1:0] out_y,
  input logic [COORD_WIDTH-1:0] out_z,
  input logic [2:0]             flip_mask,
  input logic                   last_image
);
  logic       in_acc, out_acc, start_r;
  logic [4:0] pend_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b1;
      pend_r  <= '0;
    end else begin
      if (out_acc) start_r <= last_image;
      pend_r <= pend_r + 5'(in_acc) - 5'(out_acc && last_image);
    end
  end

  // original word opens every atom, and only there
  `PBIG_ASSERT_IMPLY(a_frame, clk, rst_n, out_acc, (flip_mask == 3'b0) == start_r)
  // no result without an accepted atom
  `PBIG_ASSERT_IMPLY(a_pending, clk, rst_n, out_valid, pend_r != 5'd0)
  // drained after the last word of the last atom
  `PBIG_ASSERT_NEXT(a_drain, clk, rst_n, out_acc && last_image && pend_r == 5'd1 && !in_acc, !out_valid)
  `PBIG_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(flip_mask) && $stable(last_image))
endmodule

bind periodic_boundary_image_gen_unit pbig_chk #(.COORD_WIDTH(COORD_WIDTH)) u_pbig_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_x(out_ch.out_x), .out_y(out_ch.out_y), .out_z(out_ch.out_z),
  .flip_mask(out_ch.flip_mask), .last_image(out_ch.last_image)
);
